// ----- sv/vnhm_pkg.sv -----
package vnhm_pkg;

  // Operation codes carried in the operation field.
  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_PROBE  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_FACE   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_OFFSET_X   = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y   = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z   = 2'd2;
  localparam logic [1:0] REG_HIDE_SEAMS = 2'd3;

  // Spatial hash multipliers and fold shift.
  localparam logic [31:0] HASH_KX    = 32'd73856093;
  localparam logic [31:0] HASH_KY    = 32'd19349663;
  localparam logic [31:0] HASH_KZ    = 32'd83492791;
  localparam int          HASH_SHIFT = 15;

  // A pair must merge at least this many vertices before faces may hide.
  localparam logic [23:0] MIN_MERGES = 24'd3;

  // Accumulated contribution from the probing mesh to one inserted vertex.
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [19:0]        faces;
    logic [11:0]        merged;
    logic               ovf;
  } delta_t;

  // Saturating 24-bit signed add; bit 24 of the result flags saturation.
  function automatic logic [24:0] add_s24(logic signed [23:0] a, logic signed [15:0] b);
    logic signed [24:0] s;
    s = {a[23], a} + {{9{b[15]}}, b};
    if (s[24] != s[23]) begin
      return {1'b1, (s[24] ? 24'h800000 : 24'h7FFFFF)};
    end
    return {1'b0, s[23:0]};
  endfunction

  // Saturating 20-bit unsigned add of a 12-bit count.
  function automatic logic [20:0] add_u20(logic [19:0] a, logic [11:0] b);
    logic [20:0] s;
    s = {1'b0, a} + {9'd0, b};
    if (s[20]) begin
      return {1'b1, 20'hFFFFF};
    end
    return {1'b0, s[19:0]};
  endfunction

  // Saturating 12-bit increment.
  function automatic logic [12:0] inc_u12(logic [11:0] a);
    if (a == 12'hFFF) begin
      return {1'b1, a};
    end
    return {1'b0, a + 12'd1};
  endfunction

endpackage

// ----- sv/vnhm_ram.sv -----
module vnhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/vnhm_hash.sv -----
module vnhm_hash import vnhm_pkg::*; #(
  parameter int BW = 13
) (
  input  logic               clk,
  input  logic signed [16:0] x,
  input  logic signed [16:0] y,
  input  logic signed [16:0] z,
  output logic [BW-1:0]      bucket
);

  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] pz;
  logic [31:0] h;
  logic [31:0] hf;

  // First stage: one 32-bit product per coordinate, low word kept.
  always_ff @(posedge clk) begin
    px <= {{15{x[16]}}, x} * HASH_KX;
    py <= {{15{y[16]}}, y} * HASH_KY;
    pz <= {{15{z[16]}}, z} * HASH_KZ;
  end

  // Second stage: combine, fold high bits down and keep the bucket bits.
  always_comb begin
    h  = px ^ py ^ pz;
    hf = h ^ (h >> HASH_SHIFT);
  end

  always_ff @(posedge clk) begin
    bucket <= hf[BW-1:0];
  end

endmodule

// ----- sv/vertex_normal_hash_merge.sv -----
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+-----------------------------------------
// input    | in_valid / in_ready           | operation, side, indexes, pos, norm, faces
// output   | out_valid / out_ready         | sum_x/y/z, sum_faces, match_count, hide, overflow
// config   | APB psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One transaction is worked on at a time. An insert or probe that does nothing, and an
// unused operation, go straight to the result.
// Chain walks are paced by the vertex memory's single read port.
// After reset a clearing pass over max(BUCKETS, MAX_VERTICES) entries zeroes the
// bucket stamps, deltas and marks; no transaction is accepted until it ends.
// The output register lets the next input be accepted while a result waits.
module vertex_normal_hash_merge import vnhm_pkg::*; #(
  parameter int MAX_VERTICES = 4096,
  parameter int BUCKETS = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic               side,
  input  logic [11:0]        vertex_index,
  input  logic [11:0]        corner_b,
  input  logic [11:0]        corner_c,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic [11:0]        faces,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] sum_x,
  output logic signed [23:0] sum_y,
  output logic signed [23:0] sum_z,
  output logic [19:0]        sum_faces,
  output logic [11:0]        match_count,
  output logic               hide,
  output logic               overflow
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int BW    = $clog2(BUCKETS);
  localparam int SW    = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W = VW + 1 + 48 + 48 + 12;
  localparam int BKT_W = 16 + VW;
  localparam int DLT_W = $bits(delta_t);
  localparam int CLR_N = (BUCKETS > MAX_VERTICES) ? BUCKETS : MAX_VERTICES;
  localparam int CW    = $clog2(CLR_N);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_HASH0   = 4'd2;
  localparam logic [3:0] S_HASH1   = 4'd3;
  localparam logic [3:0] S_BKT_RD  = 4'd4;
  localparam logic [3:0] S_BKT     = 4'd5;
  localparam logic [3:0] S_VTX_CHK = 4'd6;
  localparam logic [3:0] S_DLT_UPD = 4'd7;
  localparam logic [3:0] S_DLT_RD  = 4'd8;
  localparam logic [3:0] S_DLT_OUT = 4'd9;
  localparam logic [3:0] S_MK0     = 4'd10;
  localparam logic [3:0] S_MK1     = 4'd11;
  localparam logic [3:0] S_MK2     = 4'd12;
  localparam logic [3:0] S_MK3     = 4'd13;
  localparam logic [3:0] S_FIN     = 4'd14;

  // Configuration registers.
  logic signed [13:0] offset_x;
  logic signed [13:0] offset_y;
  logic signed [13:0] offset_z;
  logic               hide_seams;

  // Control state.
  logic [3:0]    state;
  logic [CW-1:0] clr_cnt;
  logic [15:0]   build_stamp;
  logic [23:0]   pair_matches;
  logic [VW-1:0] node;
  logic [SW-1:0] step_cnt;
  logic          any_match;
  logic          all_marked;

  // Captured transaction.
  logic [2:0]         it_op;
  logic               it_side;
  logic [11:0]        it_idx;
  logic [11:0]        it_cb;
  logic [11:0]        it_cc;
  logic signed [16:0] it_qx;
  logic signed [16:0] it_qy;
  logic signed [16:0] it_qz;
  logic signed [15:0] it_nx;
  logic signed [15:0] it_ny;
  logic signed [15:0] it_nz;
  logic [11:0]        it_faces;

  // Result being built.
  logic signed [23:0] res_x;
  logic signed [23:0] res_y;
  logic signed [23:0] res_z;
  logic [19:0]        res_f;
  logic [11:0]        res_m;
  logic               res_hide;
  logic               res_ovf;

  // Memory ports.
  logic             bkt_we, bkt_re;
  logic [BW-1:0]    bkt_waddr, bkt_raddr;
  logic [BKT_W-1:0] bkt_wdata, bkt_rdata;
  logic             vtx_we, vtx_re;
  logic [VW-1:0]    vtx_waddr, vtx_raddr;
  logic [VTX_W-1:0] vtx_wdata, vtx_rdata;
  logic             dlt_we, dlt_re;
  logic [VW-1:0]    dlt_waddr, dlt_raddr;
  logic [DLT_W-1:0] dlt_wdata, dlt_rdata;
  logic             mkp_we, mki_we, mk_re;
  logic [VW-1:0]    mkp_waddr, mki_waddr, mk_raddr;
  logic [15:0]      mkp_wdata, mki_wdata, mkp_rdata, mki_rdata;

  logic [BW-1:0] hash_bkt;

  // Decoded fields of the words read back.
  logic [15:0]        b_stamp;
  logic [VW-1:0]      b_head;
  logic [VW-1:0]      v_link;
  logic               v_end;
  logic signed [15:0] v_px, v_py, v_pz;
  logic signed [15:0] v_nx, v_ny, v_nz;
  logic [11:0]        v_faces;
  delta_t             d_old, d_new;
  logic               v_match;
  logic               clearing;
  logic               in_fire;
  logic               in_idx_ok;
  logic               live;
  logic [SW-1:0]      step_next;
  logic               walk_done;
  logic [11:0]        mk_corner;
  logic               mk_ok;
  logic               mk_hit;
  logic [15:0]        mk_rd;
  logic [24:0]        a_x, a_y, a_z, e_x, e_y, e_z;
  logic [20:0]        a_f, e_f;
  logic [12:0]        a_m, e_m;
  logic               out_free;

  assign pready   = 1'b1;
  assign clearing = (state == S_CLR);
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign live     = (build_stamp != 16'd0);
  assign in_idx_ok = (32'(vertex_index) < MAX_VERTICES);
  assign out_free = !out_valid || out_ready;

  // Configuration write and read.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x   <= '0;
      offset_y   <= '0;
      offset_z   <= '0;
      hide_seams <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_OFFSET_X:   offset_x   <= pwdata[13:0];
        REG_OFFSET_Y:   offset_y   <= pwdata[13:0];
        REG_OFFSET_Z:   offset_z   <= pwdata[13:0];
        REG_HIDE_SEAMS: hide_seams <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OFFSET_X:   prdata = {18'd0, offset_x};
      REG_OFFSET_Y:   prdata = {18'd0, offset_y};
      REG_OFFSET_Z:   prdata = {18'd0, offset_z};
      REG_HIDE_SEAMS: prdata = {31'd0, hide_seams};
      default:        prdata = 32'd0;
    endcase
  end

  // Hash of the captured position (offset applied for probes).
  vnhm_hash #(.BW(BW)) u_hash (
    .clk    (clk),
    .x      (it_qx),
    .y      (it_qy),
    .z      (it_qz),
    .bucket (hash_bkt)
  );

  vnhm_ram #(.WIDTH(BKT_W), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
    .re(bkt_re), .raddr(bkt_raddr), .rdata(bkt_rdata)
  );

  vnhm_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk(clk), .we(vtx_we), .waddr(vtx_waddr), .wdata(vtx_wdata),
    .re(vtx_re), .raddr(vtx_raddr), .rdata(vtx_rdata)
  );

  vnhm_ram #(.WIDTH(DLT_W), .DEPTH(MAX_VERTICES)) u_dlt_ram (
    .clk(clk), .we(dlt_we), .waddr(dlt_waddr), .wdata(dlt_wdata),
    .re(dlt_re), .raddr(dlt_raddr), .rdata(dlt_rdata)
  );

  vnhm_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_mkp_ram (
    .clk(clk), .we(mkp_we), .waddr(mkp_waddr), .wdata(mkp_wdata),
    .re(mk_re), .raddr(mk_raddr), .rdata(mkp_rdata)
  );

  vnhm_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_mki_ram (
    .clk(clk), .we(mki_we), .waddr(mki_waddr), .wdata(mki_wdata),
    .re(mk_re), .raddr(mk_raddr), .rdata(mki_rdata)
  );

  // Field split of memory words.
  always_comb begin
    {b_stamp, b_head} = bkt_rdata;
    {v_link, v_end, v_px, v_py, v_pz, v_nx, v_ny, v_nz, v_faces} = vtx_rdata;
    d_old   = delta_t'(dlt_rdata);
    v_match = ({v_px[15], v_px} == it_qx) && ({v_py[15], v_py} == it_qy) &&
              ({v_pz[15], v_pz} == it_qz);
  end

  // Saturating accumulation for one matching node.
  always_comb begin
    a_x = add_s24(res_x, v_nx);
    a_y = add_s24(res_y, v_ny);
    a_z = add_s24(res_z, v_nz);
    a_f = add_u20(res_f, v_faces);
    a_m = inc_u12(res_m);
    e_x = add_s24(d_old.x, it_nx);
    e_y = add_s24(d_old.y, it_ny);
    e_z = add_s24(d_old.z, it_nz);
    e_f = add_u20(d_old.faces, it_faces);
    e_m = inc_u12(d_old.merged);
    d_new.x      = e_x[23:0];
    d_new.y      = e_y[23:0];
    d_new.z      = e_z[23:0];
    d_new.faces  = e_f[19:0];
    d_new.merged = e_m[11:0];
    d_new.ovf    = d_old.ovf | e_x[24] | e_y[24] | e_z[24] | e_f[20] | e_m[12];
  end

  // Chain walk ends at a chain end or after visiting every vertex slot once.
  assign step_next = step_cnt + SW'(1);
  assign walk_done = v_end || (step_next == SW'(MAX_VERTICES));

  // Face test corner selection and check.
  always_comb begin
    case (state)
      S_MK0:   mk_corner = it_idx;
      S_MK1:   mk_corner = it_cb;
      default: mk_corner = it_cc;
    endcase
  end

  logic [11:0] chk_corner;
  always_comb begin
    case (state)
      S_MK1:   chk_corner = it_idx;
      S_MK2:   chk_corner = it_cb;
      default: chk_corner = it_cc;
    endcase
    mk_ok  = (32'(chk_corner) < MAX_VERTICES);
    mk_rd  = it_side ? mki_rdata : mkp_rdata;
    mk_hit = mk_ok && (mk_rd == build_stamp);
  end

  // Memory port control.
  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = hash_bkt;
    bkt_wdata = {build_stamp, VW'(it_idx)};
    bkt_re    = (state == S_BKT_RD);
    bkt_raddr = hash_bkt;
    vtx_we    = 1'b0;
    vtx_waddr = VW'(it_idx);
    vtx_wdata = {((b_stamp != build_stamp) ? VW'(0) : b_head), (b_stamp != build_stamp),
                 it_qx[15:0], it_qy[15:0], it_qz[15:0], it_nx, it_ny, it_nz, it_faces};
    vtx_re    = 1'b0;
    vtx_raddr = b_head;
    dlt_we    = 1'b0;
    dlt_waddr = node;
    dlt_wdata = d_new;
    dlt_re    = 1'b0;
    dlt_raddr = node;
    mkp_we    = 1'b0;
    mkp_waddr = VW'(it_idx);
    mkp_wdata = build_stamp;
    mki_we    = 1'b0;
    mki_waddr = node;
    mki_wdata = build_stamp;
    mk_re     = 1'b0;
    mk_raddr  = VW'(mk_corner);
    case (state)
      S_CLR: begin
        bkt_we    = (32'(clr_cnt) < BUCKETS);
        bkt_waddr = BW'(clr_cnt);
        bkt_wdata = '0;
        dlt_we    = (32'(clr_cnt) < MAX_VERTICES);
        dlt_waddr = VW'(clr_cnt);
        dlt_wdata = '0;
        mkp_we    = dlt_we;
        mkp_waddr = VW'(clr_cnt);
        mkp_wdata = '0;
        mki_we    = dlt_we;
        mki_waddr = VW'(clr_cnt);
        mki_wdata = '0;
      end
      S_BKT: begin
        if (it_op == OP_INSERT) begin
          bkt_we = 1'b1;
          vtx_we = 1'b1;
        end else begin
          vtx_re = (b_stamp == build_stamp);
        end
      end
      S_VTX_CHK: begin
        if (v_match) begin
          dlt_re = 1'b1;
        end else begin
          vtx_re    = !walk_done;
          vtx_raddr = v_link;
        end
      end
      S_DLT_UPD: begin
        dlt_we    = 1'b1;
        mki_we    = 1'b1;
        vtx_re    = !walk_done;
        vtx_raddr = v_link;
      end
      S_DLT_RD: begin
        dlt_re    = 1'b1;
        dlt_raddr = VW'(it_idx);
      end
      S_MK0, S_MK1, S_MK2: begin
        mk_re = 1'b1;
      end
      S_FIN: begin
        mkp_we = (it_op == OP_PROBE) && any_match;
      end
      default: ;
    endcase
  end

  // Sequencer and result accumulation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_cnt      <= '0;
      build_stamp  <= '0;
      pair_matches <= '0;
      out_valid    <= 1'b0;
    end else begin
      // A result leaves here unless a new one is loaded in the same cycle.
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            it_op    <= operation;
            it_side  <= side;
            it_idx   <= vertex_index;
            it_cb    <= corner_b;
            it_cc    <= corner_c;
            it_nx    <= norm_x;
            it_ny    <= norm_y;
            it_nz    <= norm_z;
            it_faces <= faces;
            if (operation == OP_PROBE) begin
              it_qx <= {pos_x[15], pos_x} - {{3{offset_x[13]}}, offset_x};
              it_qy <= {pos_y[15], pos_y} - {{3{offset_y[13]}}, offset_y};
              it_qz <= {pos_z[15], pos_z} - {{3{offset_z[13]}}, offset_z};
            end else begin
              it_qx <= {pos_x[15], pos_x};
              it_qy <= {pos_y[15], pos_y};
              it_qz <= {pos_z[15], pos_z};
            end
            res_x      <= '0;
            res_y      <= '0;
            res_z      <= '0;
            res_f      <= '0;
            res_m      <= '0;
            res_hide   <= 1'b0;
            res_ovf    <= 1'b0;
            any_match  <= 1'b0;
            all_marked <= 1'b1;
            state      <= S_FIN;
            case (operation)
              OP_START: begin
                build_stamp  <= (build_stamp == 16'hFFFF) ? 16'd1 : build_stamp + 16'd1;
                pair_matches <= '0;
              end
              OP_INSERT, OP_PROBE: begin
                if (live && in_idx_ok && (faces != 12'd0)) begin
                  state <= S_HASH0;
                end
              end
              OP_READ: begin
                if (in_idx_ok) begin
                  state <= S_DLT_RD;
                end
              end
              OP_FACE: begin
                if (live) begin
                  state <= S_MK0;
                end
              end
              default: ;
            endcase
          end
        end
        S_HASH0:  state <= S_HASH1;
        S_HASH1:  state <= S_BKT_RD;
        S_BKT_RD: state <= S_BKT;
        S_BKT: begin
          node     <= b_head;
          step_cnt <= '0;
          if ((it_op == OP_PROBE) && (b_stamp == build_stamp)) begin
            state <= S_VTX_CHK;
          end else begin
            state <= S_FIN;
          end
        end
        S_VTX_CHK: begin
          if (v_match) begin
            state <= S_DLT_UPD;
          end else begin
            step_cnt <= step_next;
            node     <= v_link;
            state    <= walk_done ? S_FIN : S_VTX_CHK;
          end
        end
        S_DLT_UPD: begin
          res_x     <= a_x[23:0];
          res_y     <= a_y[23:0];
          res_z     <= a_z[23:0];
          res_f     <= a_f[19:0];
          res_m     <= a_m[11:0];
          res_ovf   <= res_ovf | a_x[24] | a_y[24] | a_z[24] | a_f[20] | a_m[12];
          any_match <= 1'b1;
          if (pair_matches != 24'hFFFFFF) begin
            pair_matches <= pair_matches + 24'd1;
          end
          step_cnt <= step_next;
          node     <= v_link;
          state    <= walk_done ? S_FIN : S_VTX_CHK;
        end
        S_DLT_RD: state <= S_DLT_OUT;
        S_DLT_OUT: begin
          res_x   <= d_old.x;
          res_y   <= d_old.y;
          res_z   <= d_old.z;
          res_f   <= d_old.faces;
          res_m   <= d_old.merged;
          res_ovf <= d_old.ovf;
          state   <= S_FIN;
        end
        S_MK0: state <= S_MK1;
        S_MK1, S_MK2: begin
          all_marked <= all_marked && mk_hit;
          state      <= (state == S_MK1) ? S_MK2 : S_MK3;
        end
        S_MK3: begin
          res_hide <= hide_seams && (pair_matches >= MIN_MERGES) && all_marked && mk_hit;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            sum_x       <= res_x;
            sum_y       <= res_y;
            sum_z       <= res_z;
            sum_faces   <= res_f;
            match_count <= res_m;
            hide        <= res_hide;
            overflow    <= res_ovf;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // No transaction may enter while the clearing pass runs.
  a_no_accept_in_clear: assert property (@(posedge clk) clearing |-> !in_ready)
    else $error("input accepted during clearing pass");

  // A start always leaves a live, nonzero stamp.
  a_stamp_live: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (operation == OP_START)) |=> (build_stamp != 16'd0))
    else $error("build stamp zero after start");

  // A hide result never carries probe sums.
  a_hide_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hide) |-> ((match_count == 12'd0) && (sum_faces == 20'd0)))
    else $error("hide result mixed with probe sums");

  // The chain walk stays within one pass over all vertex slots.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_VTX_CHK) |-> (32'(step_cnt) < MAX_VERTICES))
    else $error("chain walk exceeded vertex count");

endmodule
